/* hw/rtl/pars_pkg.sv */
// ----------------------------------------------------------------------------
// pars_pkg: shared types and constants for the point rotate/scale unit
// Coordinate format, CORDIC sizing, stream packing widths and the arctangent
// table used by the rotation pipeline.
// ----------------------------------------------------------------------------
package pars_pkg;

   // coordinate and angle formats
   localparam int COORD_WIDTH = 32;
   localparam int ANGLE_WIDTH = 16;
   localparam int FRAC_BITS   = 16;

   // trig values in Q2.30, angles inside the CORDIC in 2^-32 turn
   localparam int TRIG_FRAC        = 30;
   localparam int TRIG_WIDTH       = TRIG_FRAC + 2;
   localparam int TURN_WIDTH       = 32;
   localparam int Z_WIDTH          = TURN_WIDTH + 1;
   localparam int CORDIC_STEPS     = 30;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
   localparam int STEP_IDX_WIDTH   = $clog2(CORDIC_STEPS);

   // multiplier and accumulator widths
   localparam int MUL_B_WIDTH = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH;
   localparam int PROD_WIDTH  = COORD_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 1;

   // CORDIC gain 0.6072529350 in Q2.30
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = TRIG_WIDTH'(652032874);

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // stream packing
   localparam int REQ_DATA_BITS  = ANGLE_WIDTH + 4 * COORD_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int REQ_USER_WIDTH = 3;
   localparam int RSP_DATA_BITS  = 3 * COORD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_USER_WIDTH = 1;

   typedef enum logic {
      OP_ROTATE,
      OP_SCALE
   } op_type;

   typedef enum logic [1:0] {
      AXIS_NONE,
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   // request fields that travel alongside the CORDIC
   typedef struct packed {
      op_type                         op;
      axis_type                       axis;
      logic                           flip;
      logic signed [COORD_WIDTH-1:0]  factor;
      logic signed [COORD_WIDTH-1:0]  px;
      logic signed [COORD_WIDTH-1:0]  py;
      logic signed [COORD_WIDTH-1:0]  pz;
   } side_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [Z_WIDTH-1:0] cordic_atan(
      input logic [STEP_IDX_WIDTH-1:0] idx
   );
      logic signed [Z_WIDTH-1:0] val;
      unique case (idx)
         5'd0:  val = Z_WIDTH'(536870912);
         5'd1:  val = Z_WIDTH'(316933406);
         5'd2:  val = Z_WIDTH'(167458907);
         5'd3:  val = Z_WIDTH'(85004756);
         5'd4:  val = Z_WIDTH'(42667331);
         5'd5:  val = Z_WIDTH'(21354465);
         5'd6:  val = Z_WIDTH'(10679838);
         5'd7:  val = Z_WIDTH'(5340245);
         5'd8:  val = Z_WIDTH'(2670163);
         5'd9:  val = Z_WIDTH'(1335087);
         5'd10: val = Z_WIDTH'(667544);
         5'd11: val = Z_WIDTH'(333772);
         5'd12: val = Z_WIDTH'(166886);
         5'd13: val = Z_WIDTH'(83443);
         5'd14: val = Z_WIDTH'(41722);
         5'd15: val = Z_WIDTH'(20861);
         5'd16: val = Z_WIDTH'(10430);
         5'd17: val = Z_WIDTH'(5215);
         5'd18: val = Z_WIDTH'(2608);
         5'd19: val = Z_WIDTH'(1304);
         5'd20: val = Z_WIDTH'(652);
         5'd21: val = Z_WIDTH'(326);
         5'd22: val = Z_WIDTH'(163);
         5'd23: val = Z_WIDTH'(81);
         5'd24: val = Z_WIDTH'(41);
         5'd25: val = Z_WIDTH'(20);
         5'd26: val = Z_WIDTH'(10);
         5'd27: val = Z_WIDTH'(5);
         5'd28: val = Z_WIDTH'(3);
         5'd29: val = Z_WIDTH'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/point_axis_rotate_scale_unit.sv */
// ----------------------------------------------------------------------------
// point_axis_rotate_scale_unit: rotate a Q16.16 point about X/Y/Z or scale it
// A request passes through 20 registered stages (input, 15 CORDIC, trig,
// multiply, accumulate, round/saturate) on its way to rsp. Throughput: one
// request per cycle while the output is not stalled; each stage holds one
// request and a stalled output only backs up full stages.
// Reset clears the valid bits of every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
module point_axis_rotate_scale_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // angle, factor, px, py, pz (lowest bits first)
   input  logic [pars_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // operation, axis (lowest bits first)
   input  logic [pars_pkg::REQ_USER_WIDTH-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // qx, qy, qz (lowest bits first)
   output logic [pars_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // clipped
   output logic [pars_pkg::RSP_USER_WIDTH-1:0]     rsp_tuser
);
   import pars_pkg::*;

   localparam int ST_IN   = 0;
   localparam int ST_TRIG = CORDIC_STAGES + 1;
   localparam int ST_MUL  = CORDIC_STAGES + 2;
   localparam int ST_ACC  = CORDIC_STAGES + 3;
   localparam int ST_OUT  = CORDIC_STAGES + 4;
   localparam int N_ST    = CORDIC_STAGES + 5;

   // ---------------------------------------------------------------- control
   logic [N_ST-1:0] v_ff;
   logic [N_ST-1:0] v_in;
   logic [N_ST-1:0] en;

   // a stage advances when it is empty or the stage after it advances
   assign en[ST_OUT] = !v_ff[ST_OUT] || rsp_tready;
   genvar g;
   generate
      for (g = 0; g < N_ST - 1; g++) begin : g_en
         assign en[g] = !v_ff[g] || en[g+1];
      end
   endgenerate

   assign v_in       = {v_ff[N_ST-2:0], req_tvalid};
   assign req_tready = en[ST_IN];
   assign rsp_tvalid = v_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_in) | (~en & v_ff);
      end
   end

   // ----------------------------------------------------------- input stage
   logic [ANGLE_WIDTH-1:0]    req_angle;
   logic [TURN_WIDTH-1:0]     turn;
   logic                      flip;
   logic [TURN_WIDTH-1:0]     turn_folded;
   side_type                  side0_in;
   side_type                  side0_ff;
   logic signed [Z_WIDTH-1:0] z0_in;
   logic signed [Z_WIDTH-1:0] z0_ff;

   always_comb begin
      req_angle   = req_tdata[ANGLE_WIDTH-1:0];
      turn        = TURN_WIDTH'(req_angle) << (TURN_WIDTH - ANGLE_WIDTH);
      // second and third quadrant: rotate by half a turn and negate the result
      flip        = turn[TURN_WIDTH-1] ^ turn[TURN_WIDTH-2];
      turn_folded = {turn[TURN_WIDTH-1] ^ flip, turn[TURN_WIDTH-2:0]};
      z0_in       = Z_WIDTH'(signed'(turn_folded));

      side0_in.op     = op_type'(req_tuser[0]);
      side0_in.axis   = axis_type'(req_tuser[2:1]);
      side0_in.flip   = flip;
      side0_in.factor = req_tdata[ANGLE_WIDTH +: COORD_WIDTH];
      side0_in.px     = req_tdata[ANGLE_WIDTH + COORD_WIDTH +: COORD_WIDTH];
      side0_in.py     = req_tdata[ANGLE_WIDTH + 2 * COORD_WIDTH +: COORD_WIDTH];
      side0_in.pz     = req_tdata[ANGLE_WIDTH + 3 * COORD_WIDTH +: COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         side0_ff <= side0_in;
         z0_ff    <= z0_in;
      end
   end

   // ---------------------------------------------------------------- CORDIC
   logic signed [TRIG_WIDTH-1:0] cos_raw;
   logic signed [TRIG_WIDTH-1:0] sin_raw;
   side_type                     side_c;

   pars_cordic u_cordic (
      .clock      (clock),
      .stage_en   (en[CORDIC_STAGES:1]),
      .z_start    (z0_ff),
      .side_start (side0_ff),
      .cos_raw    (cos_raw),
      .sin_raw    (sin_raw),
      .side_done  (side_c)
   );

   // ------------------------------------------------------------ trig stage
   logic signed [TRIG_WIDTH-1:0] cos_ff;
   logic signed [TRIG_WIDTH-1:0] sin_ff;
   logic signed [TRIG_WIDTH-1:0] nsin_ff;
   side_type                     side_t_ff;

   always_ff @(posedge clock) begin
      if (en[ST_TRIG]) begin
         cos_ff    <= side_c.flip ? -cos_raw : cos_raw;
         sin_ff    <= side_c.flip ? -sin_raw : sin_raw;
         nsin_ff   <= side_c.flip ? sin_raw : -sin_raw;
         side_t_ff <= side_c;
      end
   end

   // -------------------------------------------------------- multiply stage
   logic signed [COORD_WIDTH-1:0] a1 [0:2];
   logic signed [COORD_WIDTH-1:0] a2 [0:2];
   logic signed [MUL_B_WIDTH-1:0] b1 [0:2];
   logic signed [MUL_B_WIDTH-1:0] b2 [0:2];
   logic [2:0]                    pass_in;
   logic signed [MUL_B_WIDTH-1:0] bc;
   logic signed [MUL_B_WIDTH-1:0] bs;
   logic signed [MUL_B_WIDTH-1:0] bns;
   logic signed [MUL_B_WIDTH-1:0] bf;
   logic signed [PROD_WIDTH-1:0]  m1_ff [0:2];
   logic signed [PROD_WIDTH-1:0]  m2_ff [0:2];
   logic [2:0]                    pass_m_ff;
   side_type                      side_m_ff;

   always_comb begin
      bc  = MUL_B_WIDTH'(cos_ff);
      bs  = MUL_B_WIDTH'(sin_ff);
      bns = MUL_B_WIDTH'(nsin_ff);
      bf  = MUL_B_WIDTH'(side_t_ff.factor);
      for (int l = 0; l < 3; l++) begin
         a1[l] = '0;
         a2[l] = '0;
         b1[l] = '0;
         b2[l] = '0;
      end
      pass_in = '0;
      if (side_t_ff.op == OP_SCALE) begin
         a1[0] = side_t_ff.px;
         a1[1] = side_t_ff.py;
         a1[2] = side_t_ff.pz;
         b1[0] = bf;
         b1[1] = bf;
         b1[2] = bf;
      end else begin
         unique case (side_t_ff.axis)
            AXIS_X: begin
               pass_in[0] = 1'b1;
               a1[1] = side_t_ff.py;  b1[1] = bc;
               a2[1] = side_t_ff.pz;  b2[1] = bns;
               a1[2] = side_t_ff.py;  b1[2] = bs;
               a2[2] = side_t_ff.pz;  b2[2] = bc;
            end
            AXIS_Y: begin
               pass_in[1] = 1'b1;
               a1[0] = side_t_ff.px;  b1[0] = bc;
               a2[0] = side_t_ff.pz;  b2[0] = bs;
               a1[2] = side_t_ff.px;  b1[2] = bns;
               a2[2] = side_t_ff.pz;  b2[2] = bc;
            end
            AXIS_Z: begin
               pass_in[2] = 1'b1;
               a1[0] = side_t_ff.px;  b1[0] = bc;
               a2[0] = side_t_ff.py;  b2[0] = bns;
               a1[1] = side_t_ff.px;  b1[1] = bs;
               a2[1] = side_t_ff.py;  b2[1] = bc;
            end
            AXIS_NONE: begin
               pass_in = '1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         for (int l = 0; l < 3; l++) begin
            m1_ff[l] <= PROD_WIDTH'(a1[l]) * PROD_WIDTH'(b1[l]);
            m2_ff[l] <= PROD_WIDTH'(a2[l]) * PROD_WIDTH'(b2[l]);
         end
         pass_m_ff <= pass_in;
         side_m_ff <= side_t_ff;
      end
   end

   // ------------------------------------------------------ accumulate stage
   logic signed [ACC_WIDTH-1:0] half;
   logic signed [ACC_WIDTH-1:0] acc_ff [0:2];
   logic [2:0]                  pass_a_ff;
   side_type                    side_a_ff;

   // add half an output LSB so the shift rounds half up
   assign half = (side_m_ff.op == OP_SCALE) ? (ACC_WIDTH'(1) << (FRAC_BITS - 1))
                                            : (ACC_WIDTH'(1) << (TRIG_FRAC - 1));

   always_ff @(posedge clock) begin
      if (en[ST_ACC]) begin
         for (int l = 0; l < 3; l++) begin
            acc_ff[l] <= ACC_WIDTH'(m1_ff[l]) + ACC_WIDTH'(m2_ff[l]) + half;
         end
         pass_a_ff <= pass_m_ff;
         side_a_ff <= side_m_ff;
      end
   end

   // ------------------------------------------------- round/saturate stage
   logic signed [ACC_WIDTH-1:0]   r     [0:2];
   logic signed [COORD_WIDTH-1:0] p_a   [0:2];
   logic signed [COORD_WIDTH-1:0] q_in  [0:2];
   logic signed [COORD_WIDTH-1:0] q_ff  [0:2];
   logic [2:0]                    over;
   logic [2:0]                    under;
   logic                          clip_in;
   logic                          clip_ff;

   always_comb begin
      p_a[0]  = side_a_ff.px;
      p_a[1]  = side_a_ff.py;
      p_a[2]  = side_a_ff.pz;
      clip_in = 1'b0;
      for (int l = 0; l < 3; l++) begin
         r[l]     = (side_a_ff.op == OP_SCALE) ? (acc_ff[l] >>> FRAC_BITS)
                                               : (acc_ff[l] >>> TRIG_FRAC);
         over[l]  = !r[l][ACC_WIDTH-1] && (|r[l][ACC_WIDTH-2:COORD_WIDTH-1]);
         under[l] = r[l][ACC_WIDTH-1] && !(&r[l][ACC_WIDTH-2:COORD_WIDTH-1]);
         priority if (pass_a_ff[l]) begin
            q_in[l] = p_a[l];
         end else if (over[l]) begin
            q_in[l] = COORD_MAX;
            clip_in = 1'b1;
         end else if (under[l]) begin
            q_in[l] = COORD_MIN;
            clip_in = 1'b1;
         end else begin
            q_in[l] = r[l][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         for (int l = 0; l < 3; l++) begin
            q_ff[l] <= q_in[l];
         end
         clip_ff <= clip_in;
      end
   end

   assign rsp_tdata = RSP_DATA_WIDTH'({q_ff[2], q_ff[1], q_ff[0]});
   assign rsp_tuser = RSP_USER_WIDTH'(clip_ff);

   // ------------------------------------------------------------ assertions
   // an empty output stage lets every stage advance
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output stage");

   // a request taken without a result leaving adds exactly one in flight
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready))
      |=> ($countones(v_ff) == $past($countones(v_ff)) + 1))
      else $error("in-flight count lost or duplicated a request");

   // a clipped result carries at least one saturated coordinate
   a_clip_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && clip_ff) |->
         (q_ff[0] == COORD_MAX || q_ff[0] == COORD_MIN ||
          q_ff[1] == COORD_MAX || q_ff[1] == COORD_MIN ||
          q_ff[2] == COORD_MAX || q_ff[2] == COORD_MIN))
      else $error("clipped flag without a saturated coordinate");

endmodule

/* hw/rtl/pars_cordic.sv */
// ----------------------------------------------------------------------------
// pars_cordic: pipelined rotation-mode CORDIC
// Two micro-rotations per register stage; each stage loads on its own enable
// so the surrounding pipeline can squeeze out bubbles. Request fields ride
// along in a side register per stage.
// ----------------------------------------------------------------------------
module pars_cordic (
   input  logic                                      clock,
   input  logic [pars_pkg::CORDIC_STAGES-1:0]        stage_en,
   input  logic signed [pars_pkg::Z_WIDTH-1:0]       z_start,
   input  pars_pkg::side_type                        side_start,
   output logic signed [pars_pkg::TRIG_WIDTH-1:0]    cos_raw,
   output logic signed [pars_pkg::TRIG_WIDTH-1:0]    sin_raw,
   output pars_pkg::side_type                        side_done
);
   import pars_pkg::*;

   logic signed [TRIG_WIDTH-1:0] x_src [0:CORDIC_STAGES];
   logic signed [TRIG_WIDTH-1:0] y_src [0:CORDIC_STAGES];
   logic signed [Z_WIDTH-1:0]    z_src [0:CORDIC_STAGES];
   side_type                     side_src [0:CORDIC_STAGES];

   logic signed [TRIG_WIDTH-1:0] x_ff [0:CORDIC_STAGES-1];
   logic signed [TRIG_WIDTH-1:0] y_ff [0:CORDIC_STAGES-1];
   logic signed [Z_WIDTH-1:0]    z_ff [0:CORDIC_STAGES-1];
   side_type                     side_ff [0:CORDIC_STAGES-1];

   assign x_src[0]    = CORDIC_GAIN;
   assign y_src[0]    = '0;
   assign z_src[0]    = z_start;
   assign side_src[0] = side_start;

   genvar k;
   generate
      for (k = 0; k < CORDIC_STAGES; k++) begin : g_stage
         logic signed [TRIG_WIDTH-1:0] x_in;
         logic signed [TRIG_WIDTH-1:0] y_in;
         logic signed [Z_WIDTH-1:0]    z_in;
         logic signed [TRIG_WIDTH-1:0] x_old;
         logic signed [TRIG_WIDTH-1:0] y_old;

         always_comb begin
            x_in  = x_src[k];
            y_in  = y_src[k];
            z_in  = z_src[k];
            x_old = x_in;
            y_old = y_in;
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
               x_old = x_in;
               y_old = y_in;
               // rotate toward zero residual angle
               if (!z_in[Z_WIDTH-1]) begin
                  x_in = x_old - (y_old >>> (CORDIC_PER_STAGE * k + j));
                  y_in = y_old + (x_old >>> (CORDIC_PER_STAGE * k + j));
                  z_in = z_in - cordic_atan(STEP_IDX_WIDTH'(CORDIC_PER_STAGE * k + j));
               end else begin
                  x_in = x_old + (y_old >>> (CORDIC_PER_STAGE * k + j));
                  y_in = y_old - (x_old >>> (CORDIC_PER_STAGE * k + j));
                  z_in = z_in + cordic_atan(STEP_IDX_WIDTH'(CORDIC_PER_STAGE * k + j));
               end
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               x_ff[k]    <= x_in;
               y_ff[k]    <= y_in;
               z_ff[k]    <= z_in;
               side_ff[k] <= side_src[k];
            end
         end

         assign x_src[k+1]    = x_ff[k];
         assign y_src[k+1]    = y_ff[k];
         assign z_src[k+1]    = z_ff[k];
         assign side_src[k+1] = side_ff[k];
      end
   endgenerate

   assign cos_raw   = x_src[CORDIC_STAGES];
   assign sin_raw   = y_src[CORDIC_STAGES];
   assign side_done = side_src[CORDIC_STAGES];

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stream-level check of point_axis_rotate_scale_unit
// Drives rotate and scale requests through the request stream and checks each
// response against a bit-exact predictor (30-step CORDIC, 128-bit products,
// round half up, saturation). Both stream sides are throttled at random in the first two phases.
// ----------------------------------------------------------------------------
module tb;
   import pars_pkg::*;

   localparam int NUM_RANDOM  = 1700;
   localparam int PHASE_ONE   = 570;
   localparam int PHASE_TWO   = 1140;
   localparam int HOLD_AT     = 1300;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 40;
   localparam logic signed [COORD_WIDTH-1:0] ONE = 32'sh0001_0000;

   // atan(2^-i) in units of 2^-32 turn
   localparam longint ARCTAN [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1
   };
   localparam longint GAIN_Q30 = 652032874;

   typedef struct {
      op_type                        op;
      axis_type                      axis;
      logic [ANGLE_WIDTH-1:0]        angle;
      logic signed [COORD_WIDTH-1:0] factor;
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic signed [COORD_WIDTH-1:0] pz;
      bit                            wait_idle;
   } point_req_type;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
      logic signed [COORD_WIDTH-1:0] qz;
      logic                          clipped;
   } point_rsp_type;

   typedef struct {
      longint cosv;
      longint sinv;
   } trig_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   point_req_type point_requests[$];
   point_rsp_type point_results_due[$];
   point_req_type offered;
   logic          req_accepted = 1'b0;
   int            req_count = 0;
   int            errors = 0;
   int            rsp_count = 0;
   int            clip_count = 0;
   int            scale_count = 0;
   int            rotate_count [4] = '{0, 0, 0, 0};
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   point_axis_rotate_scale_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // cosine and sine in Q2.30 for a binary angle
   function automatic trig_type cordic_sincos(input logic [ANGLE_WIDTH-1:0] angle);
      logic [31:0] turn;
      logic [31:0] folded;
      bit          flip;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      trig_type    res;
      turn = {angle, 16'h0000};
      // fold the second and third quadrants onto the first and fourth
      flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
      folded = flip ? turn - 32'h8000_0000 : turn;
      z = $signed(folded);
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN[i];
         end
      end
      res.cosv = flip ? -x : x;
      res.sinv = flip ? -y : y;
      return res;
   endfunction

   // round half up, drop sh fraction bits, saturate; top bit flags a clip
   function automatic logic [COORD_WIDTH:0] round_clamp(
      input logic signed [127:0] acc,
      input int                  sh
   );
      logic signed [127:0] r;
      r = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
      if (r > COORD_MAX) return {1'b1, COORD_MAX};
      if (r < COORD_MIN) return {1'b1, COORD_MIN};
      return {1'b0, r[COORD_WIDTH-1:0]};
   endfunction

   function automatic point_rsp_type transform_point(input point_req_type rq);
      logic signed [127:0]    wx;
      logic signed [127:0]    wy;
      logic signed [127:0]    wz;
      logic signed [127:0]    wf;
      logic signed [127:0]    wc;
      logic signed [127:0]    ws;
      logic [COORD_WIDTH:0]   t;
      trig_type               tr;
      point_rsp_type          res;
      wx = rq.px;
      wy = rq.py;
      wz = rq.pz;
      wf = rq.factor;
      res.qx = rq.px;
      res.qy = rq.py;
      res.qz = rq.pz;
      res.clipped = 1'b0;
      if (rq.op == OP_SCALE) begin
         t = round_clamp(wx * wf, FRAC_BITS);
         res.qx = t[COORD_WIDTH-1:0];
         res.clipped |= t[COORD_WIDTH];
         t = round_clamp(wy * wf, FRAC_BITS);
         res.qy = t[COORD_WIDTH-1:0];
         res.clipped |= t[COORD_WIDTH];
         t = round_clamp(wz * wf, FRAC_BITS);
         res.qz = t[COORD_WIDTH-1:0];
         res.clipped |= t[COORD_WIDTH];
      end else if (rq.axis != AXIS_NONE) begin
         tr = cordic_sincos(rq.angle);
         wc = tr.cosv;
         ws = tr.sinv;
         case (rq.axis)
            AXIS_X: begin
               t = round_clamp(wy * wc - wz * ws, TRIG_FRAC);
               res.qy = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
               t = round_clamp(wy * ws + wz * wc, TRIG_FRAC);
               res.qz = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
            end
            AXIS_Y: begin
               t = round_clamp(wx * wc + wz * ws, TRIG_FRAC);
               res.qx = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
               t = round_clamp(wz * wc - wx * ws, TRIG_FRAC);
               res.qz = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
            end
            default: begin
               t = round_clamp(wx * wc - wy * ws, TRIG_FRAC);
               res.qx = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
               t = round_clamp(wx * ws + wy * wc, TRIG_FRAC);
               res.qy = t[COORD_WIDTH-1:0];
               res.clipped |= t[COORD_WIDTH];
            end
         endcase
      end
      return res;
   endfunction

   function automatic point_req_type make_request(
      input op_type                        op,
      input axis_type                      axis,
      input logic [ANGLE_WIDTH-1:0]        angle,
      input logic signed [COORD_WIDTH-1:0] factor,
      input logic signed [COORD_WIDTH-1:0] px,
      input logic signed [COORD_WIDTH-1:0] py,
      input logic signed [COORD_WIDTH-1:0] pz
   );
      point_req_type rq;
      rq.op = op;
      rq.axis = axis;
      rq.angle = angle;
      rq.factor = factor;
      rq.px = px;
      rq.py = py;
      rq.pz = pz;
      rq.wait_idle = 1'b0;
      return rq;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] random_coord();
      case ($urandom_range(0, 4))
         0, 1: return $urandom();
         2: return int'($urandom_range(0, 8388607)) - 4194304;
         3: return int'($urandom_range(0, 536870911)) - 268435456;
         default: begin
            case ($urandom_range(0, 4))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return 0;
               3: return 1;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] random_factor();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return int'($urandom_range(0, 524287)) - 262144;
         2: return ($urandom_range(0, 1) ? ONE : -ONE) + int'($urandom_range(0, 255)) - 128;
         default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      endcase
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] random_angle();
      if ($urandom_range(0, 4) == 0)
         return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic int send_idle_pct(input int n);
      if (n < PHASE_ONE) return 37;
      if (n < PHASE_TWO) return 83;
      return 0;
   endfunction

   function automatic int recv_idle_pct(input int n);
      if (n < PHASE_ONE) return 83;
      if (n < PHASE_TWO) return 37;
      return 0;
   endfunction

   // request driver: change inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (point_requests.size() > 0
             && !(point_requests[0].wait_idle && point_results_due.size() != 0)
             && $urandom_range(0, 99) >= send_idle_pct(req_count)) begin
            offered = point_requests.pop_front();
            req_tdata <= {offered.pz, offered.py, offered.px, offered.factor, offered.angle};
            req_tuser <= {offered.axis, offered.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side ready, with one long hold to back up the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct(req_count));
      end
   end

   // monitor: sample both handshakes on the rising edge
   always @(posedge clock) begin
      point_rsp_type want;
      point_rsp_type got;
      req_accepted <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         point_results_due.push_back(transform_point(offered));
         req_count = req_count + 1;
         if (offered.op == OP_SCALE) scale_count = scale_count + 1;
         else rotate_count[offered.axis] = rotate_count[offered.axis] + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.qx = rsp_tdata[COORD_WIDTH-1:0];
         got.qy = rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         got.qz = rsp_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
         got.clipped = rsp_tuser[0];
         if (point_results_due.size() == 0) begin
            $error("response with no request outstanding: qx=%0d qy=%0d qz=%0d",
                   got.qx, got.qy, got.qz);
            errors = errors + 1;
         end else begin
            want = point_results_due.pop_front();
            rsp_count = rsp_count + 1;
            if (want.clipped) clip_count = clip_count + 1;
            if (got.qx !== want.qx) begin
               $error("qx: expected %0d, got %0d", want.qx, got.qx);
               errors = errors + 1;
            end
            if (got.qy !== want.qy) begin
               $error("qy: expected %0d, got %0d", want.qy, got.qy);
               errors = errors + 1;
            end
            if (got.qz !== want.qz) begin
               $error("qz: expected %0d, got %0d", want.qz, got.qz);
               errors = errors + 1;
            end
            if (got.clipped !== want.clipped) begin
               $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
               errors = errors + 1;
            end
         end
      end
   end

   initial begin
      point_req_type rq;
      // directed: passthrough, quadrant angles, saturation, rounding, ignored operands
      point_requests.push_back(make_request(OP_ROTATE, AXIS_NONE, 16'd12345, COORD_MIN,
                                            COORD_MAX, COORD_MIN, -1));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_X, 16'd0, 0,
                                            ONE, 2 * ONE, 3 * ONE));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Y, 16'd16384, 0,
                                            ONE, -2 * ONE, 3 * ONE));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Z, 16'd32768, 0,
                                            -ONE, 5 * ONE, 7));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_X, 16'd49152, 0,
                                            9, 100 * ONE, -3 * ONE));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Z, 16'hFFFF, 0,
                                            12345678, -87654321, 1));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Z, 16'd8192, 0,
                                            COORD_MAX, COORD_MAX, COORD_MAX));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Y, 16'd8192, 0,
                                            COORD_MIN, COORD_MIN, COORD_MIN));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_X, 16'd24576, 0,
                                            0, COORD_MAX, COORD_MIN));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_X, 16'd16384, 0,
                                            COORD_MIN, COORD_MIN, COORD_MIN));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Y, 16'd32768, 0,
                                            COORD_MAX, COORD_MAX, COORD_MAX));
      point_requests.push_back(make_request(OP_ROTATE, AXIS_Z, 16'd4096, COORD_MIN,
                                            3 * ONE, 4 * ONE, -5 * ONE));
      point_requests.push_back(make_request(OP_SCALE, AXIS_NONE, 16'd0, ONE,
                                            COORD_MAX, COORD_MIN, 0));
      point_requests.push_back(make_request(OP_SCALE, AXIS_NONE, 16'd0, 0,
                                            COORD_MAX, COORD_MIN, -1));
      point_requests.push_back(make_request(OP_SCALE, AXIS_X, 16'd100, COORD_MIN,
                                            COORD_MIN, COORD_MAX, ONE));
      point_requests.push_back(make_request(OP_SCALE, AXIS_Y, 16'd200, COORD_MAX,
                                            COORD_MAX, -ONE, 1));
      point_requests.push_back(make_request(OP_SCALE, AXIS_Z, 16'hFFFF, -ONE,
                                            COORD_MIN, COORD_MAX, -7 * ONE));
      point_requests.push_back(make_request(OP_SCALE, AXIS_NONE, 16'd0, 1,
                                            32768, -32768, -32769));
      point_requests.push_back(make_request(OP_SCALE, AXIS_Z, 16'hFFFF, 2 * ONE,
                                            ONE / 2, -3 * ONE, 32'h3FFF_FFFF));
      point_requests.push_back(make_request(OP_SCALE, AXIS_NONE, 16'd0, COORD_MAX,
                                            -1, 1, 0));
      for (int i = 0; i < NUM_RANDOM; i++) begin
         rq = make_request($urandom_range(0, 99) < 40 ? OP_SCALE : OP_ROTATE,
                           axis_type'($urandom_range(0, 3)), random_angle(),
                           random_factor(), random_coord(), random_coord(), random_coord());
         // hold the sender until the pipeline is empty at each phase change
         rq.wait_idle = (i == 0) || (i == PHASE_ONE - 20) || (i == PHASE_TWO - 20);
         point_requests.push_back(rq);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (point_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (point_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("tb: %0d requests, %0d responses checked (%0d clipped)",
               req_count, rsp_count, clip_count);
      $display("tb: scale %0d, rotate none/x/y/z %0d/%0d/%0d/%0d",
               scale_count, rotate_count[0], rotate_count[1], rotate_count[2],
               rotate_count[3]);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: timeout");
      $display("tb: done, errors");
      $finish;
   end

endmodule
